>>> hdl/stb_pkg.sv
// Shared types and constants for the soft timer bank.
`timescale 1ns / 1ps
package stb_pkg;
    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_CREATE = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_CHECK  = 3'd3,
        CMD_DELAY  = 3'd4
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_USE   = 2'd2;

    localparam logic [30:0] RUN_WRAP  = 31'h7fffffff;
    localparam logic [15:0] MIN_DELAY = 16'd2;
    localparam int MASK_BITS = 16;

    // Classified command handed from the front end to the timer engine.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  timer_id;
        logic        id_ok;
        logic [31:0] period;
        logic        auto_reload;
        logic [15:0] delay_ticks;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } t_state;
endpackage

>>> hdl/stb_front.sv
// Front end: accept command beats, classify and queue them.
`timescale 1ns / 1ps
module stb_front
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_timer_id,
    input  logic [31:0] i_period,
    input  logic        i_auto_reload,
    input  logic [15:0] i_delay_ticks,
    output logic        o_job_valid,
    input  logic        i_job_take,
    output t_job        o_job
);
    // Two-entry queue.
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       w_in;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    // Classify: id range check up front.
    always_comb begin
        w_in.cmd         = i_cmd;
        w_in.timer_id    = i_timer_id;
        w_in.id_ok       = ({28'd0, i_timer_id} < 32'(NUM_TIMERS));
        w_in.period      = i_period;
        w_in.auto_reload = i_auto_reload;
        w_in.delay_ticks = i_delay_ticks;
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (i_job_take)         r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_valid && o_ready} - {1'b0, i_job_take};
        end
    end
endmodule

>>> hdl/stb_engine.sv
// Back end: timer state, one timer entry per cycle on tick, result register.
`timescale 1ns / 1ps
module stb_engine
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_take,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_expired_mask,
    output logic        o_timer_expired,
    output logic        o_delay_done,
    output logic [30:0] o_run_time
);
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [31:0] r_remaining [NUM_TIMERS];
    logic [31:0] r_reload    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_periodic, r_expired, r_in_use;
    logic [15:0] r_delay_left;
    logic        r_delay_flag;
    logic [30:0] r_ticks;

    t_state  r_state, n_state;
    logic [IW-1:0] r_idx;
    logic [15:0]   r_mask;
    logic [1:0]    r_status;
    logic          r_texp;
    logic          r_out_valid;

    logic          w_last;
    logic          w_start;
    logic [IW-1:0] w_id;
    logic [30:0]   w_tick_inc;
    logic [31:0]   w_cur, w_dec;

    assign w_id  = IW'(i_job.timer_id);
    assign w_last = ({1'b0, r_idx} == (IW+1)'(NUM_TIMERS - 1));
    assign w_cur  = r_remaining[r_idx];
    assign w_dec  = w_cur - 32'd1;
    assign w_tick_inc = r_ticks + 31'd1;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid && !r_out_valid)
                    n_state = (i_job.cmd == CMD_TICK) ? S_SWEEP : S_DONE;
            end
            S_SWEEP: if (w_last) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        w_start       = 1'b0;
        o_job_take    = 1'b0;
        case (r_state)
            S_IDLE:  w_start    = i_job_valid && !r_out_valid;
            S_DONE:  o_job_take = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_periodic   <= '0;
            r_expired    <= '0;
            r_in_use     <= '0;
            r_delay_left <= '0;
            r_delay_flag <= 1'b0;
            r_ticks      <= '0;
            r_mask       <= '0;
            r_status     <= ST_OK;
            r_texp       <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_remaining[i] <= '0;
                r_reload[i]    <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;

            // Execute non-tick commands and start ticks.
            if (w_start) begin
                r_mask   <= '0;
                r_idx    <= '0;
                case (i_job.cmd)
                    CMD_TICK: begin
                        r_status <= ST_OK;
                        r_texp   <= 1'b0;
                        if (r_delay_left != 16'd0) begin
                            r_delay_left <= r_delay_left - 16'd1;
                            if (r_delay_left == 16'd1) r_delay_flag <= 1'b1;
                        end
                        r_ticks <= (w_tick_inc == RUN_WRAP) ? 31'd0 : w_tick_inc;
                    end
                    CMD_CREATE: begin
                        r_texp <= 1'b0;
                        if (!i_job.id_ok) r_status <= ST_RANGE;
                        else if (r_in_use[w_id]) r_status <= ST_USE;
                        else begin
                            r_status          <= ST_OK;
                            r_remaining[w_id] <= i_job.period;
                            r_reload[w_id]    <= i_job.period;
                            r_periodic[w_id]  <= i_job.auto_reload;
                            r_expired[w_id]   <= 1'b0;
                            r_in_use[w_id]    <= 1'b1;
                        end
                    end
                    CMD_DELETE: begin
                        r_texp <= 1'b0;
                        if (!i_job.id_ok) r_status <= ST_RANGE;
                        else if (!r_in_use[w_id]) r_status <= ST_USE;
                        else begin
                            r_status          <= ST_OK;
                            r_remaining[w_id] <= '0;
                            r_reload[w_id]    <= '0;
                            r_periodic[w_id]  <= 1'b0;
                            r_in_use[w_id]    <= 1'b0;
                        end
                    end
                    CMD_CHECK: begin
                        if (!i_job.id_ok) begin
                            r_status <= ST_RANGE;
                            r_texp   <= 1'b0;
                        end else begin
                            r_status <= ST_OK;
                            r_texp   <= r_expired[w_id];
                        end
                    end
                    CMD_DELAY: begin
                        r_status <= ST_OK;
                        r_texp   <= 1'b0;
                        if (i_job.delay_ticks != 16'd0) begin
                            r_delay_left <= (i_job.delay_ticks == 16'd1) ?
                                            MIN_DELAY : i_job.delay_ticks;
                            r_delay_flag <= 1'b0;
                        end
                    end
                    default: begin
                        r_status <= ST_OK;
                        r_texp   <= 1'b0;
                    end
                endcase
            end

            // Sweep one timer entry per cycle.
            if (r_state == S_SWEEP) begin
                if (!w_last) r_idx <= r_idx + IW'(1);
                if (w_cur != 32'd0) begin
                    r_remaining[r_idx] <= (w_dec == 32'd0 && r_periodic[r_idx]) ?
                                          r_reload[r_idx] : w_dec;
                    if (w_dec == 32'd0) begin
                        r_expired[r_idx] <= 1'b1;
                        if ({1'b0, r_idx} < (IW+1)'(MASK_BITS))
                            r_mask[4'(r_idx)] <= 1'b1;
                    end
                end
            end

            if (r_state == S_DONE) r_out_valid <= 1'b1;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_expired_mask  = r_mask;
    assign o_timer_expired = r_texp;
    assign o_delay_done    = r_delay_flag;
    assign o_run_time      = r_ticks;
endmodule

>>> hdl/soft_timer_bank_top.sv
// Top level of the soft timer bank.
// Usage:
//   Slave channel s_axis_*: one command beat per item. tdata, low bit up:
//   command[2:0], timer_id[6:3], period[38:7], auto_reload[39],
//   delay_ticks[55:40]. Master channel m_axis_*: one result beat per command.
//   tdata, low bit up: status[1:0], expired_mask[17:2], timer_expired[18],
//   delay_done[19], run_time[50:20], zero padded to 56 bits.
//   A non-tick command executes as the engine leaves idle and its result
//   is flagged valid from the done state; a tick walks the timer table one
//   entry a cycle. The single timer-update port means one item at a time.
//   A two-beat command queue keeps accepting while the engine works or
//   the result waits.
//   Reset (i_rst_n low, synchronous) clears all timers, the delay and the
//   run-time counter. If the receiver stalls, the result is held and the
//   engine waits; the queue fills and then tready drops.
`timescale 1ns / 1ps
module soft_timer_bank_top
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command, timer_id, period, auto_reload, delay_ticks
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, expired_mask, timer_expired, delay_done, run_time, pad
    output logic [55:0] m_axis_tdata
);
    logic job_valid, job_take;
    t_job job;
    logic [1:0]  status;
    logic [15:0] mask;
    logic        texp, ddone;
    logic [30:0] rt;

    stb_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[2:0]), .i_timer_id(s_axis_tdata[6:3]),
        .i_period(s_axis_tdata[38:7]), .i_auto_reload(s_axis_tdata[39]),
        .i_delay_ticks(s_axis_tdata[55:40]),
        .o_job_valid(job_valid), .i_job_take(job_take), .o_job(job)
    );

    stb_engine #(.NUM_TIMERS(NUM_TIMERS)) u_engine (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_take(job_take), .i_job(job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(status), .o_expired_mask(mask), .o_timer_expired(texp),
        .o_delay_done(ddone), .o_run_time(rt)
    );

    assign m_axis_tdata = {5'd0, rt, ddone, texp, mask, status};
endmodule

>>> hdl/stb_checker.sv
// Port-level checker for the soft timer bank, bound to the top level.
`timescale 1ns / 1ps
module stb_checker
    import stb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    // Held result stays stable.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // Status never takes an unused code.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad status");
    // Run time never reaches the wrap value.
    a_rt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[50:20] != RUN_WRAP)
        else $error("run time out of range");
    // Padding stays zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:51] == 5'd0)
        else $error("padding set");
    // No result right after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
endmodule

bind soft_timer_bank_top stb_checker u_stb_checker (.*);
